>>> sv/keyboard_scan_code_translator_assert.svh
// assertion macros for the checker file
`ifndef KEYBOARD_SCAN_CODE_TRANSLATOR_ASSERT_SVH
`define KEYBOARD_SCAN_CODE_TRANSLATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define KBDSC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kbdsc check failed");

// next-cycle implication, sampled on clk, quiet while arst_n is low
`define KBDSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kbdsc check failed");

`endif

>>> sv/kbdsc_pkg.sv
package kbdsc_pkg;

	// scan codes with an action
	localparam logic [7:0] CODE_BACKSPACE = 8'h0e;
	localparam logic [7:0] CODE_ENTER     = 8'h1c;
	localparam logic [7:0] CODE_LSHIFT    = 8'h2a;
	localparam logic [7:0] CODE_RSHIFT    = 8'h36;
	localparam logic [7:0] CODE_LSHIFT_UP = 8'haa;
	localparam logic [7:0] CODE_RSHIFT_UP = 8'hb6;
	localparam logic [7:0] CODE_CAPS      = 8'h3a;
	localparam logic [7:0] CODE_NUM       = 8'h45;
	localparam logic [7:0] CODE_SCROLL    = 8'h46;
	localparam logic [7:0] CODE_ACK       = 8'hfa;
	localparam logic [7:0] CODE_RESEND    = 8'hfe;

	localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
	localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;
	localparam logic [7:0] LED_COMMAND    = 8'hed;
	localparam logic [7:0] CASE_OFFSET    = 8'h20;
	localparam logic [7:0] LAST_CMD_RESET = 8'hff;

	localparam logic DEST_WINDOW     = 1'b0;
	localparam logic DEST_CONTROLLER = 1'b1;

	// led mask bits
	localparam logic [2:0] LED_SCROLL = 3'b001;
	localparam logic [2:0] LED_NUM    = 3'b010;
	localparam logic [2:0] LED_CAPS   = 3'b100;

	// one classified scan code: one or two results, the second always to the controller
	typedef struct packed {
		logic       two;
		logic       dest0;
		logic [7:0] byte0;
		logic [7:0] byte1;
	} entry_t;

	function automatic logic [7:0] plain_char(input logic [6:0] code);
		logic [7:0] ch;
		case (code)
			7'h02: ch = 8'h31; 7'h03: ch = 8'h32; 7'h04: ch = 8'h33; 7'h05: ch = 8'h34;
			7'h06: ch = 8'h35; 7'h07: ch = 8'h36; 7'h08: ch = 8'h37; 7'h09: ch = 8'h38;
			7'h0a: ch = 8'h39; 7'h0b: ch = 8'h30; 7'h0c: ch = 8'h2d; 7'h0d: ch = 8'h3d;
			7'h10: ch = 8'h51; 7'h11: ch = 8'h57; 7'h12: ch = 8'h45; 7'h13: ch = 8'h52;
			7'h14: ch = 8'h54; 7'h15: ch = 8'h59; 7'h16: ch = 8'h55; 7'h17: ch = 8'h49;
			7'h18: ch = 8'h4f; 7'h19: ch = 8'h50; 7'h1a: ch = 8'h5b; 7'h1b: ch = 8'h5d;
			7'h1e: ch = 8'h41; 7'h1f: ch = 8'h53; 7'h20: ch = 8'h44; 7'h21: ch = 8'h46;
			7'h22: ch = 8'h47; 7'h23: ch = 8'h48; 7'h24: ch = 8'h4a; 7'h25: ch = 8'h4b;
			7'h26: ch = 8'h4c; 7'h27: ch = 8'h3b; 7'h28: ch = 8'h27; 7'h29: ch = 8'h60;
			7'h2b: ch = 8'h5c; 7'h2c: ch = 8'h5a; 7'h2d: ch = 8'h58; 7'h2e: ch = 8'h43;
			7'h2f: ch = 8'h56; 7'h30: ch = 8'h42; 7'h31: ch = 8'h4e; 7'h32: ch = 8'h4d;
			7'h33: ch = 8'h2c; 7'h34: ch = 8'h2e; 7'h35: ch = 8'h2f; 7'h37: ch = 8'h2a;
			7'h39: ch = 8'h20;
			7'h47: ch = 8'h37; 7'h48: ch = 8'h38; 7'h49: ch = 8'h39; 7'h4a: ch = 8'h2d;
			7'h4b: ch = 8'h34; 7'h4c: ch = 8'h35; 7'h4d: ch = 8'h36; 7'h4e: ch = 8'h2b;
			7'h4f: ch = 8'h31; 7'h50: ch = 8'h32; 7'h51: ch = 8'h33; 7'h52: ch = 8'h30;
			7'h53: ch = 8'h2e;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// shifted layout differs from the plain one only on digits and punctuation
	function automatic logic [7:0] shifted_char(input logic [6:0] code);
		logic [7:0] ch;
		case (code)
			7'h02: ch = 8'h21; 7'h03: ch = 8'h40; 7'h04: ch = 8'h23; 7'h05: ch = 8'h24;
			7'h06: ch = 8'h25; 7'h07: ch = 8'h5e; 7'h08: ch = 8'h26; 7'h09: ch = 8'h2a;
			7'h0a: ch = 8'h28; 7'h0b: ch = 8'h29; 7'h0c: ch = 8'h5f; 7'h0d: ch = 8'h2b;
			7'h1a: ch = 8'h7b; 7'h1b: ch = 8'h7d; 7'h27: ch = 8'h3a; 7'h28: ch = 8'h22;
			7'h29: ch = 8'h7e; 7'h2b: ch = 8'h7c; 7'h33: ch = 8'h3c; 7'h34: ch = 8'h3e;
			7'h35: ch = 8'h3f;
			default: ch = plain_char(code);
		endcase
		return ch;
	endfunction

endpackage

>>> sv/kbdsc_front.sv
// classifies each scan code, keeps shift and lock state, builds queue entries
module kbdsc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            scan_code,
	output logic                  push,
	output kbdsc_pkg::entry_t     entry
);

	logic [1:0] shift_q;
	logic [2:0] leds_q;
	logic [7:0] last_cmd_q;

	logic [7:0] ch;
	logic [7:0] ch_cased;
	logic       is_letter;
	logic       has_result;
	logic [2:0] leds_next;
	logic [1:0] shift_next;
	logic       led_toggle;

	always_comb begin
		ch = 8'h00;
		if (!scan_code[7]) begin
			ch = (shift_q == 2'b00) ? kbdsc_pkg::plain_char(scan_code[6:0])
			                        : kbdsc_pkg::shifted_char(scan_code[6:0]);
		end
		is_letter = (ch >= 8'h41) && (ch <= 8'h5a);
		// lower case unless exactly one of caps and shift is active
		ch_cased = (is_letter && ((leds_q[2] != 1'b0) == (shift_q != 2'b00)))
			? ch + kbdsc_pkg::CASE_OFFSET : ch;
	end

	always_comb begin
		entry.two   = 1'b0;
		entry.dest0 = kbdsc_pkg::DEST_WINDOW;
		entry.byte0 = ch_cased;
		entry.byte1 = 8'h00;
		has_result  = (ch != 8'h00);
		leds_next   = leds_q;
		shift_next  = shift_q;
		led_toggle  = 1'b0;
		case (scan_code)
			kbdsc_pkg::CODE_BACKSPACE: begin
				entry.byte0 = kbdsc_pkg::CHAR_BACKSPACE;
				has_result  = 1'b1;
			end
			kbdsc_pkg::CODE_ENTER: begin
				entry.byte0 = kbdsc_pkg::CHAR_NEWLINE;
				has_result  = 1'b1;
			end
			kbdsc_pkg::CODE_LSHIFT:    shift_next = shift_q | 2'b01;
			kbdsc_pkg::CODE_RSHIFT:    shift_next = shift_q | 2'b10;
			kbdsc_pkg::CODE_LSHIFT_UP: shift_next = shift_q & 2'b10;
			kbdsc_pkg::CODE_RSHIFT_UP: shift_next = shift_q & 2'b01;
			kbdsc_pkg::CODE_CAPS: begin
				leds_next  = leds_q ^ kbdsc_pkg::LED_CAPS;
				led_toggle = 1'b1;
			end
			kbdsc_pkg::CODE_NUM: begin
				leds_next  = leds_q ^ kbdsc_pkg::LED_NUM;
				led_toggle = 1'b1;
			end
			kbdsc_pkg::CODE_SCROLL: begin
				leds_next  = leds_q ^ kbdsc_pkg::LED_SCROLL;
				led_toggle = 1'b1;
			end
			kbdsc_pkg::CODE_RESEND: begin
				entry.dest0 = kbdsc_pkg::DEST_CONTROLLER;
				entry.byte0 = last_cmd_q;
				has_result  = 1'b1;
			end
			default: begin
			end
		endcase
		if (led_toggle) begin
			entry.two   = 1'b1;
			entry.dest0 = kbdsc_pkg::DEST_CONTROLLER;
			entry.byte0 = kbdsc_pkg::LED_COMMAND;
			entry.byte1 = {5'b00000, leds_next};
			has_result  = 1'b1;
		end
		push = accept && has_result;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q    <= 2'b00;
			leds_q     <= 3'b000;
			last_cmd_q <= kbdsc_pkg::LAST_CMD_RESET;
		end else if (accept) begin
			shift_q <= shift_next;
			leds_q  <= leds_next;
			if (led_toggle) begin
				last_cmd_q <= {5'b00000, leds_next};
			end
		end
	end

endmodule

>>> sv/kbdsc_queue.sv
// two-entry queue between classifier and output sequencer
module kbdsc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  kbdsc_pkg::entry_t     push_entry,
	input  logic                  pop,
	output logic                  full,
	output logic                  not_empty,
	output kbdsc_pkg::entry_t     head
);

	kbdsc_pkg::entry_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = count_q[1];
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/kbdsc_back.sv
// splits queue entries into result items behind an output register
module kbdsc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  avail,
	input  kbdsc_pkg::entry_t     head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_data,
	output logic                  out_dest,
	output logic                  out_last
);

	logic       valid_q;
	logic       second_q;
	logic [7:0] byte1_q;
	logic [7:0] data_q;
	logic       dest_q;
	logic       last_q;
	logic       load;

	assign load      = !valid_q || out_ready;
	assign pop       = load && !second_q && avail;
	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_dest  = dest_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			if (second_q) begin
				valid_q  <= 1'b1;
				second_q <= 1'b0;
			end else begin
				valid_q  <= avail;
				second_q <= avail && head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (second_q) begin
				data_q <= byte1_q;
				dest_q <= kbdsc_pkg::DEST_CONTROLLER;
				last_q <= 1'b1;
			end else if (avail) begin
				data_q  <= head.byte0;
				dest_q  <= head.dest0;
				last_q  <= !head.two;
				byte1_q <= head.byte1;
			end
		end
	end

endmodule

>>> sv/keyboard_scan_code_translator.sv
// channel   dir  tdata          tuser            tlast
// s_axis    in   scan_code[7:0] -                -
// m_axis    out  data_byte[7:0] destination      last_of_run
//
// one scan code is accepted per cycle while the two-entry queue has room
// each scan code gives zero, one or two result items; the output register sends one per cycle
// while m_axis_tready is high, so two-result scan codes (led toggle) lower the sustained rate
// an accepted scan code enters the queue, then its first result item loads the output register
// arst_n clears shift and lock state, sets the last command byte to 0xff and empties the queue
// a stalled output fills the queue and then drops s_axis_tready; no item is lost
module keyboard_scan_code_translator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] scan_code
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] data_byte
	output logic       m_axis_tuser,   // [0] destination, 1 = keyboard controller
	output logic       m_axis_tlast    // last result item of this scan code
);

	logic              accept;
	logic              push;
	logic              pop;
	logic              full;
	logic              not_empty;
	kbdsc_pkg::entry_t push_entry;
	kbdsc_pkg::entry_t head;

	// front side only waits for queue room, never for the output
	assign s_axis_tready = !full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// classifier: table lookup, case fold, shift and lock tracking
	kbdsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.scan_code (s_axis_tdata),
		.push      (push),
		.entry     (push_entry)
	);

	// codes with no result never take a queue slot
	kbdsc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (full),
		.not_empty  (not_empty),
		.head       (head)
	);

	// sequencer: first byte, then the led mask for two-result entries
	kbdsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (not_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_dest  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

>>> sv/kbdsc_checker.sv
`include "keyboard_scan_code_translator_assert.svh"

// port-level checks on the result stream
module kbdsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tuser,
	input logic       m_axis_tlast
);

	// only the led command opens a two-item run
	`KBDSC_ASSERT_NOW(a_first_is_led_cmd, m_axis_tvalid && !m_axis_tlast, m_axis_tuser && (m_axis_tdata == kbdsc_pkg::LED_COMMAND))

	// the led mask follows the command at once
	`KBDSC_ASSERT_NEXT(a_mask_follows, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tuser && m_axis_tlast && (m_axis_tdata[7:3] == 5'b00000))

	// the command byte never ends a run
	`KBDSC_ASSERT_NOW(a_cmd_not_last, m_axis_tvalid && m_axis_tuser && (m_axis_tdata == kbdsc_pkg::LED_COMMAND), !m_axis_tlast)

	// a stalled item holds
	`KBDSC_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

endmodule

bind keyboard_scan_code_translator kbdsc_checker u_kbdsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

>>> tb/sv/tb_keyboard_scan_code_translator.sv
`timescale 1ns / 100ps

import kbdsc_pkg::*;

typedef struct packed {
	logic       dest;
	logic [7:0] data;
	logic       last;
} key_result_t;

// tracks shift, lock and controller state and queues the items each scan code should give
class scan_code_scoreboard;
	logic [1:0]  shift_keys_down;
	logic [2:0]  lock_mask;
	bit          ack_awaited;
	logic [7:0]  last_sent_byte;
	key_result_t awaited[$];
	int          mismatches;
	int          codes_seen;
	int          results_seen;
	int          controller_bytes;
	// one character per scan code from 0x00 up; lower-case n marks a code with no character
	string       plain_layout;
	string       shifted_layout;

	function new();
		shift_keys_down = 2'b00;
		lock_mask = 3'b000;
		ack_awaited = 1'b0;
		last_sent_byte = LAST_CMD_RESET;
		mismatches = 0;
		codes_seen = 0;
		results_seen = 0;
		controller_bytes = 0;
		plain_layout = {"nn1234567890-=nn", "QWERTYUIOP[]nnAS", "DFGHJKL;'\140n\\ZXCV",
			"BNM,./n*n nnnnnn", "nnnnnnn789-456+1", "230."};
		shifted_layout = {"nn!@#$%^&*()_+nn", "QWERTYUIOP{}nnAS", "DFGHJKL:\"~n|ZXCV",
			"BNM<>?n*n nnnnnn", "nnnnnnn789-456+1", "230."};
	endfunction

	function logic [7:0] layout_char(logic [7:0] code, bit shifted);
		byte c;
		if (code >= plain_layout.len())
			return 8'h00;
		c = shifted ? shifted_layout[int'(code)] : plain_layout[int'(code)];
		return (c == "n") ? 8'h00 : c;
	endfunction

	// true when the code gives a character or changes some state
	function bit acts_on(logic [7:0] code);
		return (!code[7] && layout_char(code, 1'b0) != 8'h00) ||
			(code inside {CODE_BACKSPACE, CODE_ENTER, CODE_LSHIFT, CODE_RSHIFT,
			CODE_LSHIFT_UP, CODE_RSHIFT_UP, CODE_CAPS, CODE_NUM, CODE_SCROLL,
			CODE_ACK, CODE_RESEND});
	endfunction

	function void emit(logic dest, logic [7:0] data);
		awaited.push_back('{dest, data, 1'b0});
	endfunction

	function void toggle_lock(logic [2:0] lock_bit);
		lock_mask ^= lock_bit;
		emit(DEST_CONTROLLER, LED_COMMAND);
		emit(DEST_CONTROLLER, {5'b00000, lock_mask});
		last_sent_byte = {5'b00000, lock_mask};
		ack_awaited = 1'b1;
	endfunction

	function void note_scan_code(logic [7:0] code);
		logic [7:0]  ch;
		int          first;
		key_result_t tail;
		first = awaited.size();
		codes_seen++;
		// release codes never give a character
		ch = code[7] ? 8'h00 : layout_char(code, shift_keys_down != 2'b00);
		// lower case unless exactly one of caps lock and shift is active
		if (ch >= "A" && ch <= "Z" &&
			((lock_mask & LED_CAPS) != 3'b000) == (shift_keys_down != 2'b00))
			ch += CASE_OFFSET;
		if (ch != 8'h00)
			emit(DEST_WINDOW, ch);
		case (code)
			CODE_BACKSPACE: emit(DEST_WINDOW, CHAR_BACKSPACE);
			CODE_ENTER:     emit(DEST_WINDOW, CHAR_NEWLINE);
			CODE_LSHIFT:    shift_keys_down[0] = 1'b1;
			CODE_RSHIFT:    shift_keys_down[1] = 1'b1;
			CODE_LSHIFT_UP: shift_keys_down[0] = 1'b0;
			CODE_RSHIFT_UP: shift_keys_down[1] = 1'b0;
			CODE_CAPS:      toggle_lock(LED_CAPS);
			CODE_NUM:       toggle_lock(LED_NUM);
			CODE_SCROLL:    toggle_lock(LED_SCROLL);
			CODE_ACK:       ack_awaited = 1'b0;
			CODE_RESEND: begin
				emit(DEST_CONTROLLER, last_sent_byte);
				ack_awaited = 1'b1;
			end
			default: ;
		endcase
		if (awaited.size() > first) begin
			tail = awaited.pop_back();
			tail.last = 1'b1;
			awaited.push_back(tail);
		end
	endfunction

	function void check_result(logic dest, logic [7:0] data, logic last);
		key_result_t want;
		results_seen++;
		if (dest == DEST_CONTROLLER)
			controller_bytes++;
		if (awaited.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected item, got destination %0d data %02h last %0d",
				$time, dest, data, last);
			return;
		end
		want = awaited.pop_front();
		if (want.dest !== dest) begin
			mismatches++;
			$display("%0t: destination expected %0d got %0d", $time, want.dest, dest);
		end
		if (want.data !== data) begin
			mismatches++;
			$display("%0t: data byte expected %02h got %02h", $time, want.data, data);
		end
		if (want.last !== last) begin
			mismatches++;
			$display("%0t: last of run expected %0d got %0d", $time, want.last, last);
		end
	endfunction
endclass

module tb_keyboard_scan_code_translator;

	localparam int ACTIVE_PER_PHASE = 120;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT      = 2000;
	localparam int SETTLE_CYCLES    = 20;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tuser;
	logic       m_axis_tlast;

	scan_code_scoreboard sb;
	int send_idle_pct = 20;
	int recv_stall_pct = 73;
	int hold_asked = 0;
	int hold_given = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	logic [7:0] opening_codes[$] = '{CODE_RESEND, 8'h00, 8'hff, 8'h7f, 8'h80, 8'h1e, 8'h07,
		8'h08, CODE_BACKSPACE, CODE_ENTER, CODE_LSHIFT, 8'h07, 8'h08, 8'h1e, CODE_CAPS, 8'h1e,
		CODE_LSHIFT_UP, 8'h1e, CODE_RSHIFT, 8'h1a, CODE_RSHIFT_UP, CODE_NUM, CODE_SCROLL,
		CODE_ACK, CODE_RESEND};

	keyboard_scan_code_translator uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	// receiver: random stalls, plus a long hold-off whenever one is asked for
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else if (hold_asked != hold_given) begin
			hold_given++;
			hold_left = LONG_HOLD_CYCLES - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// handshake monitor and watchdog
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			sb.note_scan_code(s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles, %0d items still awaited",
				$time, QUIET_LIMIT, sb.awaited.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_scan_code(input logic [7:0] code);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= code;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// sender pauses until every awaited item has come back
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.awaited.size() != 0);
	endtask

	// mostly key presses and state codes, the rest releases and noise
	function automatic logic [7:0] pick_scan_code();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 8'($urandom_range(1, 8'h58));
		if (roll < 62) begin
			case ($urandom_range(0, 3))
				0: return CODE_LSHIFT;
				1: return CODE_RSHIFT;
				2: return CODE_LSHIFT_UP;
				default: return CODE_RSHIFT_UP;
			endcase
		end
		if (roll < 70) begin
			case ($urandom_range(0, 2))
				0: return CODE_CAPS;
				1: return CODE_NUM;
				default: return CODE_SCROLL;
			endcase
		end
		if (roll < 76)
			return ($urandom_range(0, 1) != 0) ? CODE_ACK : CODE_RESEND;
		if (roll < 82)
			return ($urandom_range(0, 1) != 0) ? CODE_BACKSPACE : CODE_ENTER;
		if (roll < 90)
			return 8'($urandom_range(1, 8'h58)) | 8'h80;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic run_random(input int count);
		int         active;
		logic [7:0] code;
		active = 0;
		while (active < count) begin
			code = pick_scan_code();
			if (sb.acts_on(code))
				active++;
			send_scan_code(code);
		end
	endtask

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles lightly, receiver stalls heavily
		foreach (opening_codes[i])
			send_scan_code(opening_codes[i]);
		run_random(ACTIVE_PER_PHASE);
		drain();

		// the other way round
		send_idle_pct = 73;
		recv_stall_pct = 20;
		run_random(ACTIVE_PER_PHASE);
		drain();

		// full speed, opening with a long receiver hold-off so the input backs up
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_asked++;
		run_random(ACTIVE_PER_PHASE);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("run covered %0d scan codes (%0d directed) and %0d result items,",
			sb.codes_seen, opening_codes.size(), sb.results_seen);
		$display("%0d of them bytes to the controller, with %0d mismatches",
			sb.controller_bytes, sb.mismatches);
		if (sb.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
